>>> src/plms_pkg.sv
// shared codes and constants for the point light merge and nearest select block
`default_nettype none

package plms_pkg;

  // input transaction kinds
  localparam logic [1:0] MODE_CLEAR    = 2'd0;
  localparam logic [1:0] MODE_ADD      = 2'd1;
  localparam logic [1:0] MODE_SELECT   = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  // configuration register indexes
  localparam logic [0:0] CFG_LIGHT_ENABLE     = 1'd0;
  localparam logic [0:0] CFG_FLICKER_RESPONSE = 1'd1;

  // field widths
  localparam int COORD_W = 20;
  localparam int POS_W   = 3 * COORD_W;
  localparam int CHAN_W  = 16;
  localparam int COL_W   = 3 * CHAN_W;
  localparam int RAD_W   = 16;
  localparam int LAMP_W  = POS_W + COL_W + RAD_W;
  localparam int PREV_W  = POS_W + COL_W;
  localparam int DIST_W  = 42;
  localparam int IN_TDATA_W  = 192;
  localparam int OUT_TDATA_W = 128;
  localparam int CFG_W   = 17;

  // merge and easing distance threshold
  localparam logic [DIST_W-1:0] MERGE_DIST2 = 42'd3600;

  // easing factor: a = (3932*65536 + 61604*f + 32768) >> 16
  localparam logic [33:0] A_OFFSET     = 34'd257720320;
  localparam logic [16:0] A_SLOPE      = 17'd61604;
  localparam logic [16:0] A_ONE        = 17'd65536;
  localparam logic [16:0] A_RESET      = 17'd34734;
  localparam logic [16:0] SMOOTH_LIMIT = 17'd65470;
  localparam logic [DIST_W-1:0] ROUND_HALF = 42'd32768;

endpackage

`default_nettype wire

>>> src/plms_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module plms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/point_light_merge_and_nearest_select.sv
// point light table with merge on add and nearest-first selection with colour easing
// clear resets the light count; add scans the stored lights and appends if none is close (a
//   merge is written at the end of the matching entry's scan)
// select: with more than ACTIVE_LIMIT lights, each pick walks the table through the shared
//   distance unit (picked lights are skipped without a read); each emitted light is then
//   loaded, eased from the nearest close previous light when smoothing is on, and emitted
// one transaction in flight at a time; results go out through an output register
// reset clears control state and counts; table memories hold no reset and need no clearing
`default_nettype none

module point_light_merge_and_nearest_select #(
  parameter int COLLECT_DEPTH = 96,
  parameter int ACTIVE_LIMIT  = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode, pos_x, pos_y, pos_z, red, green, blue, light_radius, cam_x, cam_y, cam_z
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z, out_red, out_green, out_blue, out_radius
  output logic [127:0] m_axis_tdata,
  output logic         m_axis_tlast,
  // empty_res
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_addr_i,
  input  logic [16:0]  cfg_wdata_i
);

  localparam int CIW = (COLLECT_DEPTH > 1) ? $clog2(COLLECT_DEPTH) : 1;
  localparam int CCW = $clog2(COLLECT_DEPTH + 1);
  localparam int AIW = (ACTIVE_LIMIT > 1) ? $clog2(ACTIVE_LIMIT) : 1;
  localparam int ACW = $clog2(ACTIVE_LIMIT + 1);
  localparam int PDEPTH = 2 * (2 ** AIW);

  typedef enum logic [9:0] {
    ST_IDLE       = 10'b0000000001,
    ST_ADD_SCAN   = 10'b0000000010,
    ST_ADD_APPEND = 10'b0000000100,
    ST_KNN_SCAN   = 10'b0000001000,
    ST_SM_LOAD    = 10'b0000010000,
    ST_SM_SCAN    = 10'b0000100000,
    ST_SM_PREV    = 10'b0001000000,
    ST_SM_EASE    = 10'b0010000000,
    ST_EMIT       = 10'b0100000000,
    ST_EMPTY      = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [CCW-1:0] cnt_q, cnt_d;
  logic [ACW-1:0] pcnt_q, pcnt_d;
  logic           bank_q, bank_d;
  logic           en_q, en_d;
  logic [16:0]    a_q, a_d;
  logic           out_vld_q, out_vld_d;
  logic [2:0]     ph_q, ph_d;
  logic [1:0]     ch_q, ch_d;
  logic [CCW-1:0] ci_q, ci_d;
  logic [ACW-1:0] pj_q, pj_d;
  logic [ACW-1:0] oi_q, oi_d;
  logic [ACW-1:0] ocnt_q, ocnt_d;
  logic           found_q, found_d;
  logic           big_q, big_d;

  logic [plms_pkg::POS_W-1:0]  np_q, np_d;
  logic [plms_pkg::COL_W-1:0]  ncol_q, ncol_d;
  logic [plms_pkg::RAD_W-1:0]  nrad_q, nrad_d;
  logic [plms_pkg::POS_W-1:0]  cam_q, cam_d;
  logic [plms_pkg::LAMP_W-1:0] cur_q, cur_d;
  logic [plms_pkg::COL_W-1:0]  pcol_q, pcol_d;
  logic [plms_pkg::DIST_W-1:0] acc_q, acc_d;
  logic [plms_pkg::DIST_W-1:0] bd_q, bd_d;
  logic [CIW-1:0]              bestc_q, bestc_d;
  logic [AIW-1:0]              bestp_q, bestp_d;
  logic [CIW-1:0]              pick_q [ACTIVE_LIMIT];
  logic [CIW-1:0]              pick_d [ACTIVE_LIMIT];
  logic [COLLECT_DEPTH-1:0]    used_q, used_d;
  logic [plms_pkg::LAMP_W-1:0] odata_q, odata_d;
  logic                        olast_q, olast_d;
  logic                        ouser_q, ouser_d;
  logic signed [43:0]          mul_q;

  // memory ports
  logic                        c_we;
  logic [CIW-1:0]              c_waddr, c_raddr;
  logic [plms_pkg::LAMP_W-1:0] c_wdata, c_rdata;
  logic                        p_we;
  logic [AIW:0]                p_waddr, p_raddr;
  logic [plms_pkg::PREV_W-1:0] p_wdata, p_rdata;

  // shared datapath signals
  logic [plms_pkg::POS_W-1:0]   scan_pt, ref_pt;
  logic [plms_pkg::COORD_W-1:0] da, db;
  logic signed [20:0]           diff;
  logic signed [21:0]           mul_x, mul_y;
  logic [plms_pkg::DIST_W-1:0]  dist_now, ease_sum;
  logic [15:0]                  ease_res, ep, ec;
  logic [16:0]                  inv_a;
  logic [plms_pkg::LAMP_W-1:0]  merged;
  logic                         smooth;
  logic [16:0]                  fsat;
  logic [33:0]                  a_tmp;
  logic                         upd, adv, emit_last, in_acc;
  logic [CIW-1:0]               pick_sel;

  plms_ram #(
    .WIDTH(plms_pkg::LAMP_W),
    .DEPTH(COLLECT_DEPTH)
  ) u_collect_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(c_waddr),
    .wdata_i(c_wdata),
    .raddr_i(c_raddr),
    .rdata_o(c_rdata)
  );

  plms_ram #(
    .WIDTH(plms_pkg::PREV_W),
    .DEPTH(PDEPTH)
  ) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  // distance operand selection
  always_comb begin
    scan_pt = (state_q == ST_SM_SCAN) ? p_rdata[plms_pkg::POS_W-1:0]
                                      : c_rdata[plms_pkg::POS_W-1:0];
    if (state_q == ST_ADD_SCAN) begin
      ref_pt = np_q;
    end else if (state_q == ST_KNN_SCAN) begin
      ref_pt = cam_q;
    end else begin
      ref_pt = cur_q[plms_pkg::POS_W-1:0];
    end
    case (ph_q)
      3'd1: begin
        da = scan_pt[19:0];
        db = ref_pt[19:0];
      end
      3'd2: begin
        da = scan_pt[39:20];
        db = ref_pt[39:20];
      end
      default: begin
        da = scan_pt[59:40];
        db = ref_pt[59:40];
      end
    endcase
    diff = $signed({da[19], da}) - $signed({db[19], db});
  end

  // easing operands
  always_comb begin
    case (ch_q)
      2'd0: begin
        ep = pcol_q[15:0];
        ec = cur_q[75:60];
      end
      2'd1: begin
        ep = pcol_q[31:16];
        ec = cur_q[91:76];
      end
      default: begin
        ep = pcol_q[47:32];
        ec = cur_q[107:92];
      end
    endcase
    inv_a = plms_pkg::A_ONE - a_q;
  end

  // shared multiplier operands
  always_comb begin
    if (state_q == ST_SM_EASE) begin
      if (ph_q == 3'd0) begin
        mul_x = $signed({6'd0, ep});
        mul_y = $signed({5'd0, inv_a});
      end else begin
        mul_x = $signed({6'd0, ec});
        mul_y = $signed({5'd0, a_q});
      end
    end else begin
      mul_x = {diff[20], diff};
      mul_y = {diff[20], diff};
    end
  end

  assign dist_now = acc_q + mul_q[41:0];
  assign ease_sum = acc_q + mul_q[41:0] + plms_pkg::ROUND_HALF;
  assign ease_res = ease_sum[31:16];
  assign smooth   = (a_q < plms_pkg::SMOOTH_LIMIT);

  // merge of the new light into the entry under the scan
  always_comb begin
    merged = c_rdata;
    if (ncol_q[15:0] > c_rdata[75:60]) merged[75:60] = ncol_q[15:0];
    if (ncol_q[31:16] > c_rdata[91:76]) merged[91:76] = ncol_q[31:16];
    if (ncol_q[47:32] > c_rdata[107:92]) merged[107:92] = ncol_q[47:32];
    if (nrad_q > c_rdata[123:108]) merged[123:108] = nrad_q;
  end

  // easing factor from the flicker setting
  always_comb begin
    fsat  = (cfg_wdata_i > plms_pkg::A_ONE) ? plms_pkg::A_ONE : cfg_wdata_i;
    a_tmp = plms_pkg::A_OFFSET + 34'(fsat) * 34'(plms_pkg::A_SLOPE);
  end

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign emit_last = ((ACW+1)'(oi_q) + 1'b1) == (ACW+1)'(ocnt_q);

  // sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pcnt_d    = pcnt_q;
    bank_d    = bank_q;
    en_d      = en_q;
    a_d       = a_q;
    out_vld_d = out_vld_q & ~m_axis_tready;
    ph_d      = ph_q;
    ch_d      = ch_q;
    ci_d      = ci_q;
    pj_d      = pj_q;
    oi_d      = oi_q;
    ocnt_d    = ocnt_q;
    found_d   = found_q;
    big_d     = big_q;
    np_d      = np_q;
    ncol_d    = ncol_q;
    nrad_d    = nrad_q;
    cam_d     = cam_q;
    cur_d     = cur_q;
    pcol_d    = pcol_q;
    acc_d     = acc_q;
    bd_d      = bd_q;
    bestc_d   = bestc_q;
    bestp_d   = bestp_q;
    pick_d    = pick_q;
    used_d    = used_q;
    odata_d   = odata_q;
    olast_d   = olast_q;
    ouser_d   = ouser_q;
    c_we      = 1'b0;
    c_waddr   = ci_q[CIW-1:0];
    c_wdata   = merged;
    c_raddr   = ci_q[CIW-1:0];
    p_we      = 1'b0;
    p_waddr   = {~bank_q, oi_q[AIW-1:0]};
    p_wdata   = cur_q[plms_pkg::PREV_W-1:0];
    p_raddr   = {bank_q, pj_q[AIW-1:0]};
    upd       = 1'b0;
    adv       = 1'b0;
    pick_sel  = bestc_q;

    // distance accumulation over the three axes
    if ((state_q == ST_ADD_SCAN) || (state_q == ST_KNN_SCAN) || (state_q == ST_SM_SCAN)) begin
      if (ph_q == 3'd2) begin
        acc_d = mul_q[41:0];
      end else if (ph_q == 3'd3) begin
        acc_d = acc_q + mul_q[41:0];
      end
    end

    // configuration writes
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        plms_pkg::CFG_LIGHT_ENABLE:     en_d = cfg_wdata_i[0];
        plms_pkg::CFG_FLICKER_RESPONSE: a_d  = a_tmp[32:16];
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ph_d = 3'd0;
          unique case (s_axis_tdata[1:0])
            plms_pkg::MODE_CLEAR: cnt_d = '0;
            plms_pkg::MODE_ADD: begin
              if (en_q) begin
                np_d    = s_axis_tdata[61:2];
                ncol_d  = s_axis_tdata[109:62];
                nrad_d  = s_axis_tdata[125:110];
                ci_d    = '0;
                state_d = (cnt_q == '0) ? ST_ADD_APPEND : ST_ADD_SCAN;
              end
            end
            plms_pkg::MODE_SELECT: begin
              cam_d = s_axis_tdata[185:126];
              oi_d  = '0;
              if (cnt_q == '0) begin
                state_d = ST_EMPTY;
              end else if (int'(cnt_q) > ACTIVE_LIMIT) begin
                used_d  = '0;
                ci_d    = '0;
                found_d = 1'b0;
                big_d   = 1'b1;
                ocnt_d  = ACW'(ACTIVE_LIMIT);
                state_d = ST_KNN_SCAN;
              end else begin
                big_d   = 1'b0;
                ocnt_d  = ACW'(cnt_q);
                state_d = ST_SM_LOAD;
              end
            end
            default: ;
          endcase
        end
      end

      ST_ADD_SCAN: begin
        if (ph_q != 3'd4) begin
          ph_d = ph_q + 3'd1;
        end else if (dist_now < plms_pkg::MERGE_DIST2) begin
          c_we    = 1'b1;
          state_d = ST_IDLE;
        end else if ((ci_q + 1'b1) == cnt_q) begin
          state_d = ST_ADD_APPEND;
        end else begin
          ci_d = ci_q + 1'b1;
          ph_d = 3'd0;
        end
      end

      ST_ADD_APPEND: begin
        if (int'(cnt_q) < COLLECT_DEPTH) begin
          c_we    = 1'b1;
          c_waddr = cnt_q[CIW-1:0];
          c_wdata = {nrad_q, ncol_q, np_q};
          cnt_d   = cnt_q + 1'b1;
        end
        state_d = ST_IDLE;
      end

      ST_KNN_SCAN: begin
        // picked entries are skipped without a read
        if (ph_q == 3'd0) begin
          if (used_q[ci_q[CIW-1:0]]) begin
            adv = 1'b1;
          end else begin
            ph_d = 3'd1;
          end
        end else if (ph_q != 3'd4) begin
          ph_d = ph_q + 3'd1;
        end else begin
          upd = !found_q || (dist_now < bd_q);
          adv = 1'b1;
        end
        if (upd) begin
          bd_d    = dist_now;
          bestc_d = ci_q[CIW-1:0];
          found_d = 1'b1;
        end
        if (adv) begin
          ph_d = 3'd0;
          if ((ci_q + 1'b1) == cnt_q) begin
            pick_sel = upd ? ci_q[CIW-1:0] : bestc_q;
            pick_d[oi_q[AIW-1:0]] = pick_sel;
            used_d[pick_sel] = 1'b1;
            found_d = 1'b0;
            ci_d    = '0;
            if (emit_last) begin
              oi_d    = '0;
              state_d = ST_SM_LOAD;
            end else begin
              oi_d = oi_q + 1'b1;
            end
          end else begin
            ci_d = ci_q + 1'b1;
          end
        end
      end

      ST_SM_LOAD: begin
        c_raddr = big_q ? pick_q[oi_q[AIW-1:0]] : CIW'(oi_q);
        if (ph_q == 3'd0) begin
          ph_d = 3'd1;
        end else begin
          cur_d   = c_rdata;
          ph_d    = 3'd0;
          pj_d    = '0;
          found_d = 1'b0;
          bd_d    = plms_pkg::MERGE_DIST2;
          state_d = (smooth && (pcnt_q != '0)) ? ST_SM_SCAN : ST_EMIT;
        end
      end

      ST_SM_SCAN: begin
        if (ph_q != 3'd4) begin
          ph_d = ph_q + 3'd1;
        end else begin
          upd  = dist_now < bd_q;
          ph_d = 3'd0;
          if (upd) begin
            bd_d    = dist_now;
            bestp_d = pj_q[AIW-1:0];
            found_d = 1'b1;
          end
          if ((pj_q + 1'b1) == pcnt_q) begin
            state_d = (found_q || upd) ? ST_SM_PREV : ST_EMIT;
          end else begin
            pj_d = pj_q + 1'b1;
          end
        end
      end

      ST_SM_PREV: begin
        p_raddr = {bank_q, bestp_q};
        if (ph_q == 3'd0) begin
          ph_d = 3'd1;
        end else begin
          pcol_d  = p_rdata[plms_pkg::PREV_W-1:plms_pkg::POS_W];
          ph_d    = 3'd0;
          ch_d    = 2'd0;
          state_d = ST_SM_EASE;
        end
      end

      ST_SM_EASE: begin
        // previous times (1 - a), then current times a, then round
        if (ph_q == 3'd0) begin
          ph_d = 3'd1;
        end else if (ph_q == 3'd1) begin
          acc_d = mul_q[41:0];
          ph_d  = 3'd2;
        end else begin
          case (ch_q)
            2'd0:    cur_d[75:60]  = ease_res;
            2'd1:    cur_d[91:76]  = ease_res;
            default: cur_d[107:92] = ease_res;
          endcase
          ph_d = 3'd0;
          if (ch_q == 2'd2) begin
            state_d = ST_EMIT;
          end else begin
            ch_d = ch_q + 2'd1;
          end
        end
      end

      ST_EMIT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          odata_d   = cur_q;
          olast_d   = emit_last;
          ouser_d   = 1'b0;
          p_we      = 1'b1;
          if (emit_last) begin
            bank_d  = ~bank_q;
            pcnt_d  = ocnt_q;
            state_d = ST_IDLE;
          end else begin
            oi_d    = oi_q + 1'b1;
            ph_d    = 3'd0;
            state_d = ST_SM_LOAD;
          end
        end
      end

      ST_EMPTY: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          odata_d   = '0;
          olast_d   = 1'b1;
          ouser_d   = 1'b1;
          pcnt_d    = '0;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      pcnt_q    <= '0;
      bank_q    <= 1'b0;
      en_q      <= 1'b0;
      a_q       <= plms_pkg::A_RESET;
      out_vld_q <= 1'b0;
      ph_q      <= '0;
      ch_q      <= '0;
      ci_q      <= '0;
      pj_q      <= '0;
      oi_q      <= '0;
      ocnt_q    <= '0;
      found_q   <= 1'b0;
      big_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pcnt_q    <= pcnt_d;
      bank_q    <= bank_d;
      en_q      <= en_d;
      a_q       <= a_d;
      out_vld_q <= out_vld_d;
      ph_q      <= ph_d;
      ch_q      <= ch_d;
      ci_q      <= ci_d;
      pj_q      <= pj_d;
      oi_q      <= oi_d;
      ocnt_q    <= ocnt_d;
      found_q   <= found_d;
      big_q     <= big_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    np_q    <= np_d;
    ncol_q  <= ncol_d;
    nrad_q  <= nrad_d;
    cam_q   <= cam_d;
    cur_q   <= cur_d;
    pcol_q  <= pcol_d;
    acc_q   <= acc_d;
    bd_q    <= bd_d;
    bestc_q <= bestc_d;
    bestp_q <= bestp_d;
    pick_q  <= pick_d;
    used_q  <= used_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
    ouser_q <= ouser_d;
    mul_q   <= mul_x * mul_y;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, odata_q};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ouser_q;

endmodule

`default_nettype wire

>>> src/plms_check.sv
// port-level checks for the point light merge and nearest select block
`default_nettype none

module plms_check (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [191:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tlast,
  input logic         m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // empty result is a lone zero transaction
  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("empty result malformed");

  // a select always keeps the block busy afterwards
  a_select_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == plms_pkg::MODE_SELECT)
      |=> !s_axis_tready)
    else $error("ready after select");

  // mid-run results mean the select is still in progress
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready during a result run");

endmodule

bind point_light_merge_and_nearest_select plms_check u_plms_check (.*);

`default_nettype wire

>>> verif/point_light_merge_and_nearest_select_test.sv
// testbench for the point light merge table with nearest-first selection and colour easing
`default_nettype none

module point_light_merge_and_nearest_select_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [19:0] p [3];
    logic [15:0] c [3];
    logic [15:0] r;
  } lamp_t;

  typedef struct {
    logic [127:0] data;
    logic last;
    logic empty;
  } light_out_t;

  // shadow of the block state and its prediction of emitted lights
  class light_scoreboard;
    lamp_t table_q [$];
    lamp_t prev_q [$];
    bit enable;
    int unsigned flicker = 32768;
    light_out_t pending_q [$];
    int errors;

    function longint unsigned dist2(lamp_t a, lamp_t b);
      longint unsigned s;
      longint d;
      s = 0;
      for (int k = 0; k < 3; k++) begin
        d = longint'(a.p[k]) - longint'(b.p[k]);
        s += d * d;
      end
      return s;
    endfunction

    function light_out_t pack_light(lamp_t l, bit lst);
      light_out_t o;
      o.data = {4'd0, l.r, l.c[2], l.c[1], l.c[0], l.p[2], l.p[1], l.p[0]};
      o.last = lst;
      o.empty = 1'b0;
      return o;
    endfunction

    function void config_write(logic [0:0] idx, logic [16:0] val);
      if (idx == plms_pkg::CFG_LIGHT_ENABLE) enable = val[0];
      else flicker = (val > 65536) ? 65536 : val;
    endfunction

    // note one accepted input transaction
    function void note_input(logic [191:0] d);
      lamp_t n, cam;
      lamp_t act [$];
      bit used [96];
      longint unsigned bd, dd, a;
      int best, pb;
      bit found, merged;
      n.p[0] = d[21:2]; n.p[1] = d[41:22]; n.p[2] = d[61:42];
      n.c[0] = d[77:62]; n.c[1] = d[93:78]; n.c[2] = d[109:94];
      n.r = d[125:110];
      cam.p[0] = d[145:126]; cam.p[1] = d[165:146]; cam.p[2] = d[185:166];
      case (d[1:0])
        plms_pkg::MODE_CLEAR: table_q.delete();
        plms_pkg::MODE_ADD: if (enable) begin
          merged = 0;
          foreach (table_q[i]) if (!merged && dist2(table_q[i], n) < 3600) begin
            for (int k = 0; k < 3; k++) if (n.c[k] > table_q[i].c[k]) table_q[i].c[k] = n.c[k];
            if (n.r > table_q[i].r) table_q[i].r = n.r;
            merged = 1;
          end
          if (!merged && table_q.size() < 96) table_q.push_back(n);
        end
        plms_pkg::MODE_SELECT: begin
          if (table_q.size() == 0) begin
            pending_q.push_back('{data: '0, last: 1'b1, empty: 1'b1});
            prev_q.delete();
          end else begin
            if (table_q.size() <= 24) act = table_q;
            else begin
              foreach (used[i]) used[i] = 0;
              for (int j = 0; j < 24; j++) begin
                found = 0; best = 0; bd = 0;
                foreach (table_q[i]) if (!used[i]) begin
                  dd = dist2(table_q[i], cam);
                  if (!found || dd < bd) begin
                    bd = dd; best = i; found = 1;
                  end
                end
                used[best] = 1;
                act.push_back(table_q[best]);
              end
            end
            a = (64'd3932 * 65536 + 64'd61604 * flicker + 32768) >> 16;
            if (a < 65470) foreach (act[i]) begin
              found = 0; pb = 0; bd = 3600;
              foreach (prev_q[j]) begin
                dd = dist2(act[i], prev_q[j]);
                if (dd < bd) begin
                  bd = dd; pb = j; found = 1;
                end
              end
              if (found) for (int k = 0; k < 3; k++)
                act[i].c[k] = 16'((longint'(prev_q[pb].c[k]) * (65536 - a)
                                   + longint'(act[i].c[k]) * a + 32768) >> 16);
            end
            prev_q = act;
            foreach (act[i]) pending_q.push_back(pack_light(act[i], i == act.size() - 1));
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // check one accepted result against the oldest expected light
    task check_light(logic [127:0] d, logic lst, logic emp);
      light_out_t e;
      if (pending_q.size() == 0) begin
        report("result with none expected");
        return;
      end
      e = pending_q.pop_front();
      if (d[19:0] !== e.data[19:0]) report($sformatf("x %h vs %h", d[19:0], e.data[19:0]));
      if (d[39:20] !== e.data[39:20]) report($sformatf("y %h vs %h", d[39:20], e.data[39:20]));
      if (d[59:40] !== e.data[59:40]) report($sformatf("z %h vs %h", d[59:40], e.data[59:40]));
      if (d[75:60] !== e.data[75:60]) report($sformatf("red %h vs %h", d[75:60], e.data[75:60]));
      if (d[91:76] !== e.data[91:76])
        report($sformatf("green %h vs %h", d[91:76], e.data[91:76]));
      if (d[107:92] !== e.data[107:92])
        report($sformatf("blue %h vs %h", d[107:92], e.data[107:92]));
      if (d[123:108] !== e.data[123:108])
        report($sformatf("radius %h vs %h", d[123:108], e.data[123:108]));
      if (lst !== e.last) report($sformatf("last %b vs %b", lst, e.last));
      if (emp !== e.empty) report($sformatf("empty %b vs %b", emp, e.empty));
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [127:0] m_axis_tdata;
  logic m_axis_tlast, m_axis_tuser;
  logic cfg_we_i = 0;
  logic [0:0] cfg_addr_i = '0;
  logic [16:0] cfg_wdata_i = '0;

  light_scoreboard sb = new();
  int hold_cycles;
  bit quiet_mode;
  lamp_t cluster [$];

  point_light_merge_and_nearest_select dut (.*);

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, optional long hold
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_light(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 10);
  end

  initial begin
    #200ms;
    $display("[point_light_merge_and_nearest_select] ERROR");
    $finish;
  end

  // valid stays up after acceptance until the next transaction or an idle cycle
  task automatic send(logic [191:0] d);
    if (!quiet_mode) while ($urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(d);
  endtask

  function automatic logic [191:0] build(logic [1:0] m, lamp_t l, lamp_t cam);
    return {6'd0, cam.p[2], cam.p[1], cam.p[0], l.r, l.c[2], l.c[1], l.c[0],
            l.p[2], l.p[1], l.p[0], m};
  endfunction

  function automatic lamp_t rand_lamp(int spread);
    lamp_t l;
    for (int k = 0; k < 3; k++) begin
      l.p[k] = (spread == 0) ? 20'($urandom) : 20'($signed($urandom_range(2 * spread)) - spread);
      l.c[k] = 16'($urandom);
    end
    l.r = 16'($urandom);
    return l;
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [16:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.config_write(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_rand(int spread);
    lamp_t l, cam, near;
    int r;
    r = $urandom_range(99);
    l = rand_lamp(spread);
    cam = rand_lamp(spread);
    // revisit a known spot to hit merges and easing
    if (cluster.size() != 0 && $urandom_range(2) == 0) begin
      near = cluster[$urandom_range(cluster.size() - 1)];
      for (int k = 0; k < 3; k++) l.p[k] = near.p[k] + 20'($signed($urandom_range(60)) - 30);
    end else if (cluster.size() < 40) cluster.push_back(l);
    if (r < 4) send(build(plms_pkg::MODE_CLEAR, l, cam));
    else if (r < 80) send(build(plms_pkg::MODE_ADD, l, cam));
    else if (r < 97) send(build(plms_pkg::MODE_SELECT, l, cam));
    else send(build(plms_pkg::MODE_RESERVED, l, cam));
  endtask

  initial begin
    lamp_t l, z;
    z = '{p: '{0, 0, 0}, c: '{0, 0, 0}, r: 0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty select, disabled add, unused mode
    send(build(plms_pkg::MODE_SELECT, z, z));
    send(build(plms_pkg::MODE_ADD, rand_lamp(0), z));
    send(build(plms_pkg::MODE_SELECT, z, z));
    send(build(plms_pkg::MODE_RESERVED, rand_lamp(0), z));
    drain();
    write_cfg(plms_pkg::CFG_LIGHT_ENABLE, 17'd1);
    write_cfg(plms_pkg::CFG_FLICKER_RESPONSE, 17'd0);
    // extremes and a merge
    l = '{p: '{20'h80000, 20'h80000, 20'h80000}, c: '{16'hffff, 0, 16'hffff}, r: 16'hffff};
    send(build(plms_pkg::MODE_ADD, l, z));
    l = '{p: '{20'h7ffff, 20'h7ffff, 20'h7ffff}, c: '{0, 16'hffff, 0}, r: 0};
    send(build(plms_pkg::MODE_ADD, l, z));
    l.p[0] = 20'h7ffc4; l.c = '{16'h1234, 0, 16'h8000}; l.r = 16'h10;
    send(build(plms_pkg::MODE_ADD, l, z));
    send(build(plms_pkg::MODE_SELECT, z, l));
    l.c = '{0, 0, 0};
    send(build(plms_pkg::MODE_ADD, l, z));
    send(build(plms_pkg::MODE_SELECT, z, z));
    // overfill the table to reach the drop path
    for (int i = 0; i < 97; i++) begin
      l = rand_lamp(0);
      send(build(plms_pkg::MODE_ADD, l, z));
    end
    send(build(plms_pkg::MODE_SELECT, z, z));
    send(build(plms_pkg::MODE_CLEAR, z, z));
    send(build(plms_pkg::MODE_SELECT, z, z));
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_cfg(plms_pkg::CFG_FLICKER_RESPONSE, 17'd65536);
        1: write_cfg(plms_pkg::CFG_FLICKER_RESPONSE, 17'h1ffff);
        2: write_cfg(plms_pkg::CFG_FLICKER_RESPONSE, 17'd65000);
        3: write_cfg(plms_pkg::CFG_LIGHT_ENABLE, 17'd0);
        4: write_cfg(plms_pkg::CFG_LIGHT_ENABLE, 17'd1);
        default: write_cfg(plms_pkg::CFG_FLICKER_RESPONSE, 17'($urandom_range(65536)));
      endcase
      quiet_mode = (ph == 2);
      // long receiver hold, then a select followed by further inputs
      if (ph == 1) begin
        hold_cycles = 3000;
        send(build(plms_pkg::MODE_SELECT, z, rand_lamp(400)));
      end
      for (int i = 0; i < 12; i++) send_rand(ph == 4 ? 0 : 400);
      send(build(plms_pkg::MODE_SELECT, z, rand_lamp(400)));
      drain();
    end
    quiet_mode = 0;

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("[point_light_merge_and_nearest_select] OK");
    else
      $display("[point_light_merge_and_nearest_select] ERROR");
    $finish;
  end
endmodule

`default_nettype wire

>>> point_light_merge_and_nearest_select.f
src/plms_pkg.sv
src/plms_ram.sv
src/point_light_merge_and_nearest_select.sv
src/plms_check.sv
verif/point_light_merge_and_nearest_select_test.sv
